/* rtl/ows_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ows_pkg
// Shared types and constants for the 1-Wire ROM search unit.
// ----------------------------------------------------------------------------
package ows_pkg;

  // width of one rom code
  localparam int ROM_W = 64;

  // default depth of the rom code table
  localparam int MAX_DEVICES_DEF = 8;

  // request codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PASS  = 2'd1,
    OP_BIT   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BIT    = 3'd1,
    ST_PASS   = 3'd2,
    ST_DONE   = 3'd3,
    ST_NORESP = 3'd4,
    ST_IDLE   = 3'd5
  } status_t;

endpackage

/* rtl/ows_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ows_table
// Rom code table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ows_table
  import ows_pkg::*;
#(
  parameter int DEPTH  = MAX_DEVICES_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [ROM_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [ROM_W-1:0]  rdata
);

  logic [ROM_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/one_wire_rom_search_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_rom_search_unit
// Search engine of a 1-Wire master: walks the rom code tree bit pair by bit
// pair and stores each code found in a table.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | in_valid / in_stall     | op, no_presence, id_bit,
//          |                         | complement_bit, device_index
//  out     | out_valid / out_stall   | status, direction_bit, rom_code,
//          |                         | device_count
//
// Start, pass start and bit pair requests give their result in the cycle
// after acceptance; a read request goes through the registered read port of
// the table memory, then the output register. in_stall is high while a read
// is in flight and while an unaccepted result sits in the output register.
// One request every cycle for non-read ops while the output is not stalled.
// Reset is synchronous and clears the search state; the table is not cleared.
// ----------------------------------------------------------------------------
module one_wire_rom_search_unit
  import ows_pkg::*;
#(
  parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic        no_presence,
  input  logic        id_bit,
  input  logic        complement_bit,
  input  logic [2:0]  device_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        direction_bit,
  output logic [63:0] rom_code,
  output logic [3:0]  device_count
);

  localparam int ADDR_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNT_W  = $clog2(MAX_DEVICES + 1);
  localparam int CMP_W  = (CNT_W > 3) ? CNT_W : 3;
  localparam int POS_W  = $clog2(ROM_W) + 1;
  localparam logic [POS_W-1:0] NO_PASS = POS_W'(ROM_W);
  localparam logic [POS_W-2:0] LAST_BIT = '1;

  // highest set bit of a 64-bit mask, two levels of eight
  function automatic logic [5:0] highest_mark(input logic [63:0] m);
    logic [7:0] grp;
    logic [2:0] g;
    logic [2:0] b;
    logic [7:0] sel;
    g = 3'd0;
    b = 3'd0;
    for (int k = 0; k < 8; k++) begin
      grp[k] = |m[8*k +: 8];
    end
    for (int k = 0; k < 8; k++) begin
      if (grp[k]) g = 3'(k);
    end
    sel = m[8*g +: 8];
    for (int k = 0; k < 8; k++) begin
      if (sel[k]) b = 3'(k);
    end
    return {g, b};
  endfunction

  // search state
  logic                 active, active_next;
  logic [POS_W-1:0]     bit_pos, bit_pos_next;
  logic [POS_W-2:0]     branch, branch_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [ROM_W-1:0]     mask, mask_next;
  logic [ROM_W-1:0]     wrom, wrom_next;

  // read tracking
  logic                 rd_pending;
  logic                 rd_hit;
  logic                 rd_hit_next;

  // result of the current request
  status_t              res_status;
  logic                 res_dir;
  logic [ROM_W-1:0]     res_rom;
  status_t              status_q;

  logic                 accept;
  logic                 tbl_we;
  logic                 rd_req;
  logic [ROM_W-1:0]     rd_data;
  logic [1:0]           pair;
  logic [5:0]           hi;
  logic [ROM_W-1:0]     bit_sel;

  assign in_stall = rd_pending | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;
  assign pair     = {id_bit, complement_bit};
  assign hi       = highest_mark(mask);
  assign bit_sel  = ROM_W'(1) << bit_pos[POS_W-2:0];
  assign status   = status_q;

  // next state and result
  always_comb begin
    active_next  = active;
    bit_pos_next = bit_pos;
    branch_next  = branch;
    count_next   = count;
    mask_next    = mask;
    wrom_next    = wrom;
    res_status   = ST_OK;
    res_dir      = 1'b0;
    res_rom      = '0;
    tbl_we       = 1'b0;
    rd_req       = 1'b0;
    rd_hit_next  = (CMP_W'(device_index) < CMP_W'(count)) &&
                   (CMP_W'(device_index) < CMP_W'(MAX_DEVICES));
    case (op_t'(op))
      OP_START: begin
        mask_next    = '0;
        wrom_next    = '0;
        count_next   = '0;
        branch_next  = '0;
        bit_pos_next = NO_PASS;
        active_next  = 1'b1;
      end
      OP_PASS: begin
        if (!active) begin
          res_status = ST_IDLE;
        end else if (count >= CNT_W'(MAX_DEVICES)) begin
          active_next  = 1'b0;
          bit_pos_next = NO_PASS;
          res_status   = ST_DONE;
        end else if (no_presence) begin
          active_next  = 1'b0;
          bit_pos_next = NO_PASS;
          res_status   = ST_NORESP;
        end else if (count == '0) begin
          mask_next    = '0;
          wrom_next    = '0;
          branch_next  = '0;
          bit_pos_next = '0;
        end else if (mask == '0) begin
          active_next  = 1'b0;
          bit_pos_next = NO_PASS;
          res_status   = ST_DONE;
        end else begin
          branch_next  = hi;
          mask_next    = mask & ~(ROM_W'(1) << hi);
          wrom_next    = wrom & ((ROM_W'(1) << hi) - ROM_W'(1));
          bit_pos_next = '0;
        end
      end
      OP_BIT: begin
        if (!active || bit_pos[POS_W-1]) begin
          res_status = ST_IDLE;
        end else if (pair == 2'b11) begin
          active_next  = 1'b0;
          bit_pos_next = NO_PASS;
          res_status   = ST_NORESP;
        end else begin
          // replay below the branch, zero at it, else follow the response (one at a conflict)
          if (count != '0 && bit_pos[POS_W-2:0] < branch) begin
            res_dir = wrom[bit_pos[POS_W-2:0]];
          end else if (count != '0 && bit_pos[POS_W-2:0] == branch) begin
            res_dir = 1'b0;
          end else if (pair == 2'b01) begin
            res_dir = 1'b0;
          end else if (pair == 2'b10) begin
            res_dir = 1'b1;
          end else begin
            mask_next = mask | bit_sel;
            res_dir   = 1'b1;
          end
          wrom_next    = res_dir ? (wrom | bit_sel) : (wrom & ~bit_sel);
          bit_pos_next = bit_pos + POS_W'(1);
          if (bit_pos[POS_W-2:0] == LAST_BIT) begin
            res_status = ST_PASS;
            res_rom    = wrom_next;
            if (count < CNT_W'(MAX_DEVICES)) begin
              tbl_we     = accept;
              count_next = count + CNT_W'(1);
            end
          end else begin
            res_status = ST_BIT;
          end
        end
      end
      OP_READ: begin
        rd_req = accept;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // state, read tracking and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      bit_pos    <= '0;
      branch     <= '0;
      count      <= '0;
      mask       <= '0;
      wrom       <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (rd_pending) begin
        rd_pending    <= 1'b0;
        out_valid     <= 1'b1;
        status_q      <= ST_OK;
        direction_bit <= 1'b0;
        rom_code      <= rd_hit ? rd_data : '0;
        device_count  <= 4'(count);
      end else if (accept) begin
        if (rd_req) begin
          // any earlier result leaves at this edge
          rd_pending <= 1'b1;
          rd_hit     <= rd_hit_next;
          out_valid  <= 1'b0;
        end else begin
          active        <= active_next;
          bit_pos       <= bit_pos_next;
          branch        <= branch_next;
          count         <= count_next;
          mask          <= mask_next;
          wrom          <= wrom_next;
          out_valid     <= 1'b1;
          status_q      <= res_status;
          direction_bit <= res_dir;
          rom_code      <= res_rom;
          device_count  <= 4'(count_next);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // rom code table
  ows_table #(
    .DEPTH  (MAX_DEVICES),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (wrom_next),
    .re    (rd_req),
    .raddr (ADDR_W'(device_index)),
    .rdata (rd_data)
  );

endmodule

/* tb/rom_search_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_search_checker
// Watches both channels of the rom search unit. It keeps its own copy of the
// search state: conflict marks, the code being walked, the table of codes
// found so far. From that copy it works out the answer to every accepted
// request and compares each result with the oldest answer still due.
// ----------------------------------------------------------------------------
module rom_search_checker
  import ows_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic        no_presence,
  input  logic        id_bit,
  input  logic        complement_bit,
  input  logic [2:0]  device_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic        direction_bit,
  input  logic [63:0] rom_code,
  input  logic [3:0]  device_count,
  output int          bad_count,
  output int          due_count
);

  localparam int         TABLE_DEPTH = MAX_DEVICES_DEF;
  localparam logic [6:0] NO_PASS     = 7'd64;

  typedef struct {
    status_t     st;
    logic        dir;
    logic [63:0] code;
    logic [3:0]  cnt;
  } answer_t;

  answer_t     answers_due[$];
  answer_t     got;
  int          misses;

  // mirrored search state
  logic [63:0] found_codes [TABLE_DEPTH];
  logic [63:0] conflicts;
  logic [63:0] path;
  logic [6:0]  bit_pos;
  logic [6:0]  branch;
  logic [3:0]  found;
  logic        searching;

  task automatic flag_mismatch(string what);
    misses++;
    $display("%0t ns  checker: %s", $realtime, what);
  endtask

  function automatic answer_t make_answer(status_t st, logic dir, logic [63:0] code);
    answer_t a;
    a.st   = st;
    a.dir  = dir;
    a.code = code;
    a.cnt  = found;
    return a;
  endfunction

  // one request through the tree walk; updates the mirrored state
  function automatic answer_t walk_tree(logic [1:0] o, logic np, logic id, logic cmp,
                                        logic [2:0] idx);
    answer_t    a;
    logic [1:0] pair;
    logic       dir;
    a = make_answer(ST_OK, 1'b0, '0);
    case (op_t'(o))
      OP_START: begin
        conflicts = '0;
        path      = '0;
        found     = '0;
        branch    = '0;
        bit_pos   = NO_PASS;
        searching = 1'b1;
        a = make_answer(ST_OK, 1'b0, '0);
      end
      OP_PASS: begin
        if (!searching) begin
          a = make_answer(ST_IDLE, 1'b0, '0);
        end else if (found >= TABLE_DEPTH) begin
          searching = 1'b0;
          bit_pos   = NO_PASS;
          a = make_answer(ST_DONE, 1'b0, '0);
        end else if (np) begin
          searching = 1'b0;
          bit_pos   = NO_PASS;
          a = make_answer(ST_NORESP, 1'b0, '0);
        end else if (found != 0 && conflicts == '0) begin
          searching = 1'b0;
          bit_pos   = NO_PASS;
          a = make_answer(ST_DONE, 1'b0, '0);
        end else begin
          if (found == 0) begin
            conflicts = '0;
            path      = '0;
            branch    = '0;
          end else begin
            // branch at the highest open conflict, keep the bits below it
            branch = 7'd63;
            while (branch != 0 && !conflicts[branch[5:0]]) branch--;
            conflicts[branch[5:0]] = 1'b0;
            path = path & ((64'd1 << branch) - 64'd1);
          end
          bit_pos = '0;
          a = make_answer(ST_OK, 1'b0, '0);
        end
      end
      OP_BIT: begin
        pair = {id, cmp};
        if (!searching || bit_pos >= NO_PASS) begin
          a = make_answer(ST_IDLE, 1'b0, '0);
        end else if (pair == 2'b11) begin
          // nobody on the bus drove the pair
          searching = 1'b0;
          bit_pos   = NO_PASS;
          a = make_answer(ST_NORESP, 1'b0, '0);
        end else begin
          if (found != 0 && bit_pos < branch) dir = path[bit_pos[5:0]];
          else if (found != 0 && bit_pos == branch) dir = 1'b0;
          else if (pair == 2'b01) dir = 1'b0;
          else if (pair == 2'b10) dir = 1'b1;
          else begin
            conflicts[bit_pos[5:0]] = 1'b1;
            dir = 1'b1;
          end
          path[bit_pos[5:0]] = dir;
          bit_pos = bit_pos + 7'd1;
          if (bit_pos < NO_PASS) begin
            a = make_answer(ST_BIT, dir, '0);
          end else begin
            if (found < TABLE_DEPTH) begin
              found_codes[found[2:0]] = path;
              found = found + 4'd1;
            end
            a = make_answer(ST_PASS, dir, path);
          end
        end
      end
      default: begin
        if (idx < found && idx < TABLE_DEPTH) a = make_answer(ST_OK, 1'b0, found_codes[idx]);
        else a = make_answer(ST_OK, 1'b0, '0);
      end
    endcase
    return a;
  endfunction

  // compare results, then queue the answer of a new request
  always @(posedge clk) begin
    if (rst) begin
      conflicts = '0;
      path      = '0;
      bit_pos   = '0;
      branch    = '0;
      found     = '0;
      searching = 1'b0;
      misses    = 0;
      answers_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          flag_mismatch($sformatf("result with nothing due, status %0d", status));
        end else begin
          got = answers_due.pop_front();
          if (status !== got.st)
            flag_mismatch($sformatf("status %0d, want %s", status, got.st.name()));
          if (direction_bit !== got.dir)
            flag_mismatch($sformatf("direction_bit %b, want %b", direction_bit, got.dir));
          if (rom_code !== got.code)
            flag_mismatch($sformatf("rom_code %h, want %h", rom_code, got.code));
          if (device_count !== got.cnt)
            flag_mismatch($sformatf("device_count %0d, want %0d", device_count, got.cnt));
        end
      end
      if (in_valid && !in_stall)
        answers_due.push_back(walk_tree(op, no_presence, id_bit, complement_bit,
                                        device_index));
    end
    bad_count <= misses;
    due_count <= answers_due.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the rom search unit with whole searches: a start, then passes of a
// pass start and 64 bit pairs with random responses, some dense in conflicts
// so the table fills, some sparse so the tree runs out. Reads, aborted passes,
// missing presence, dead bus pairs and stray requests are mixed in. Both
// channels idle at random; the checker beside the block scores the results.
// ----------------------------------------------------------------------------
module testbench;
  import ows_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  op_t         op;
  logic        no_presence;
  logic        id_bit;
  logic        complement_bit;
  logic [2:0]  device_index;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic        direction_bit;
  logic [63:0] rom_code;
  logic [3:0]  device_count;

  int bad_count;
  int due_count;
  int sent;
  bit table_ready;
  bit in_calm;
  bit out_calm;

  one_wire_rom_search_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .no_presence    (no_presence),
    .id_bit         (id_bit),
    .complement_bit (complement_bit),
    .device_index   (device_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .direction_bit  (direction_bit),
    .rom_code       (rom_code),
    .device_count   (device_count)
  );

  rom_search_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .no_presence    (no_presence),
    .id_bit         (id_bit),
    .complement_bit (complement_bit),
    .device_index   (device_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .direction_bit  (direction_bit),
    .rom_code       (rom_code),
    .device_count   (device_count),
    .bad_count      (bad_count),
    .due_count      (due_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // random payload bits
  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [2:0] any_index();
    return 3'($urandom_range(0, 7));
  endfunction

  // one request: random gap, then hold until accepted
  task automatic issue(op_t o, logic np, logic id, logic cmp, logic [2:0] idx);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    op             <= o;
    no_presence    <= np;
    id_bit         <= id;
    complement_bit <= cmp;
    device_index   <= idx;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // one search; cprob is the chance in 16 that a pair is a conflict
  task automatic run_search(int passes, int cprob, bit clean);
    int         r;
    int         stop_at;
    logic [1:0] pr;
    issue(OP_START, coin(), coin(), coin(), any_index());
    for (int p = 0; p < passes; p++) begin
      issue(OP_PASS, clean ? 1'b0 : ($urandom_range(0, 11) == 0), coin(), coin(),
            any_index());
      stop_at = (!clean && $urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : 64;
      for (int b = 0; b < stop_at; b++) begin
        // stray reads and noise between pairs
        if (!clean && table_ready) begin
          r = $urandom_range(0, 59);
          if (r < 2)
            issue(OP_READ, coin(), coin(), coin(), any_index());
          else if (r == 2)
            issue(op_t'($urandom_range(0, 3)), coin(), coin(), coin(), any_index());
        end
        r = $urandom_range(0, 15);
        if (!clean && $urandom_range(0, 299) == 0) pr = 2'b11;
        else if (r < cprob) pr = 2'b00;
        else pr = $urandom_range(0, 1) ? 2'b01 : 2'b10;
        issue(OP_BIT, coin(), pr[1], pr[0], any_index());
      end
    end
    // read back the table
    if (table_ready) begin
      repeat ($urandom_range(1, 4))
        issue(OP_READ, coin(), coin(), coin(), any_index());
    end
  endtask

  // result side stall
  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int cprob;
    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = OP_START;
    no_presence    = 1'b0;
    id_bit         = 1'b0;
    complement_bit = 1'b0;
    device_index   = 3'd0;
    sent           = 0;
    table_ready    = 1'b0;
    in_calm        = 1'b0;
    out_calm       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle engine ignores pass start and bit pairs
    issue(OP_PASS, 1'b0, 1'b1, 1'b0, 3'd7);
    issue(OP_BIT, 1'b1, 1'b0, 1'b1, 3'd0);
    // bit pair with no pass open, then a missing presence
    issue(OP_START, 1'b1, 1'b1, 1'b1, 3'd7);
    issue(OP_BIT, 1'b0, 1'b1, 1'b0, 3'd0);
    issue(OP_PASS, 1'b1, 1'b0, 1'b0, 3'd0);
    issue(OP_PASS, 1'b0, 1'b0, 1'b0, 3'd0);
    // first pass: each response kind, then abandon it mid way
    issue(OP_START, 1'b0, 1'b0, 1'b0, 3'd0);
    issue(OP_PASS, 1'b0, 1'b1, 1'b1, 3'd7);
    issue(OP_BIT, 1'b0, 1'b0, 1'b1, 3'd0);
    issue(OP_BIT, 1'b1, 1'b1, 1'b0, 3'd7);
    issue(OP_BIT, 1'b0, 1'b0, 1'b0, 3'd0);
    issue(OP_PASS, 1'b0, 1'b0, 1'b0, 3'd0);
    issue(OP_BIT, 1'b0, 1'b0, 1'b0, 3'd0);
    // dead bus pair ends the search
    issue(OP_BIT, 1'b0, 1'b1, 1'b1, 3'd0);
    issue(OP_BIT, 1'b0, 1'b0, 1'b1, 3'd0);
    issue(OP_START, 1'b0, 1'b0, 1'b0, 3'd0);
    issue(OP_START, 1'b1, 1'b1, 1'b1, 3'd7);

    // dense search fills the whole table, the next pass start finds it full
    run_search(8, 12, 1'b1);
    issue(OP_PASS, 1'b0, 1'b0, 1'b0, 3'd0);
    table_ready = 1'b1;
    for (int i = 0; i < 8; i++)
      issue(OP_READ, coin(), coin(), coin(), 3'(i));

    // mixed searches
    while (sent < 620) begin
      case ($urandom_range(0, 3))
        0: cprob = 0;
        1: cprob = 1;
        2: cprob = 4;
        default: cprob = 8;
      endcase
      run_search($urandom_range(1, 2), cprob, 1'b0);
    end
    in_valid <= 1'b0;

    // drain
    while (due_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ows_pkg.sv
rtl/ows_table.sv
rtl/one_wire_rom_search_unit.sv
tb/rom_search_checker.sv
tb/testbench.sv
